FILE: rtl/lifn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIF neuron update package
// Shared types, constants and register indices for the neuron update block.
// ----------------------------------------------------------------------------
package lifn_pkg;

  localparam int NEURONS_DEFAULT = 1024;
  localparam int FIFO_DEPTH_DEFAULT = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_STAGES = 8;
  localparam int DIV_BITS_PER_STAGE = 2;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [31:0] MAX_Q16 = 32'h7fff_ffff;

  localparam logic [16:0] LEAK_FACTOR_RESET = 17'd3277;
  localparam logic [16:0] STEP_TIME_RESET = 17'd66;
  localparam logic [30:0] STEP_RATE_RESET = 31'd65536000;
  localparam logic [30:0] REFRACTORY_PERIOD_RESET = 31'd131;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t CFG_LEAK_FACTOR = 3'd0;
  localparam cfg_index_t CFG_STEP_TIME = 3'd1;
  localparam cfg_index_t CFG_STEP_RATE = 3'd2;
  localparam cfg_index_t CFG_REFRACTORY_PERIOD = 3'd3;

  typedef struct packed {
    logic [9:0] neuron_index;
    logic signed [31:0] input_current;
  } item_t;

  typedef struct packed {
    logic [9:0] spike_neuron;
    logic spike;
  } result_t;

  typedef struct packed {
    logic valid;
    logic live;
    logic [9:0] idx;
  } ctl_t;

  typedef struct packed {
    ctl_t ctl;
    logic [30:0] refr;
    logic [16:0] v_new;
    logic spike;
    logic dv_pos;
    logic sat;
  } div_tag_t;

endpackage

FILE: rtl/lifn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIF generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module lifn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/lifn_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIF overshoot divider
// Pipelined restoring divider giving a 16-bit fraction of rem / divisor.
// ----------------------------------------------------------------------------
module lifn_divider (
  input  logic                clk,
  input  logic                rst,
  input  lifn_pkg::div_tag_t  tag,
  input  logic [33:0]         rem,
  input  logic [33:0]         divisor,
  output lifn_pkg::div_tag_t  tag_out,
  output logic [15:0]         quotient,
  output lifn_pkg::ctl_t      stage_ctl [lifn_pkg::DIV_STAGES]
);
  import lifn_pkg::*;

  div_tag_t tag_q [DIV_STAGES];
  logic [33:0] rem_q [DIV_STAGES];
  logic [33:0] d_q [DIV_STAGES];
  logic [15:0] q_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    div_tag_t tag_in;
    logic [33:0] rem_in, d_in, rem_nx;
    logic [15:0] q_in, q_nx;
    logic [34:0] shifted;

    if (s == 0) begin : g_first
      assign tag_in = tag;
      assign rem_in = rem;
      assign d_in = divisor;
      assign q_in = '0;
    end else begin : g_rest
      assign tag_in = tag_q[s-1];
      assign rem_in = rem_q[s-1];
      assign d_in = d_q[s-1];
      assign q_in = q_q[s-1];
    end

    always_comb begin
      rem_nx = rem_in;
      q_nx = q_in;
      for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
        shifted = {rem_nx, 1'b0};
        if (shifted >= {1'b0, d_in}) begin
          rem_nx = 34'(shifted - {1'b0, d_in});
          q_nx = {q_nx[14:0], 1'b1};
        end else begin
          rem_nx = shifted[33:0];
          q_nx = {q_nx[14:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      tag_q[s] <= tag_in;
      rem_q[s] <= rem_nx;
      d_q[s] <= d_in;
      q_q[s] <= q_nx;
      if (rst) begin
        tag_q[s].ctl.valid <= 1'b0;
      end
    end

    assign stage_ctl[s] = tag_q[s].ctl;
  end

  assign tag_out = tag_q[DIV_STAGES-1];
  assign quotient = q_q[DIV_STAGES-1];

endmodule

FILE: rtl/lifn_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIF result FIFO
// Holds finished results until the downstream side takes them.
// ----------------------------------------------------------------------------
module lifn_fifo #(
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lifn_pkg::result_t  push_data,
  input  logic               pop,
  output logic               not_empty,
  output lifn_pkg::result_t  head
);
  import lifn_pkg::*;

  result_t slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr + 1'b1);
      end
      count <= (AW+1)'(count + push - pop);
    end
  end

  assign not_empty = (count != '0);
  assign head = slots[rd_ptr];

endmodule

FILE: rtl/lif_neuron_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIF neuron update
// Leaky integrate-and-fire step for one neuron per word, state in RAM.
// ----------------------------------------------------------------------------
//  Channel  Signals                               Direction
//  item     item_valid, item_ready, item          in
//  result   result_valid, result_ready, result    out
//  cfg      cfg_valid, cfg_ready, cfg_index/data  in
//
// One word is taken per cycle given FIFO room and words for different neurons.
// A word is held back while an earlier word for the same neuron is still in
// the 14-stage read-modify-write pipeline around the state RAMs.
// After reset a clearing pass over every address zeroes both RAMs; no word is
// taken meanwhile. Results wait in a FIFO and stalls never halt the pipeline.
module lif_neuron_update #(
  parameter int NEURONS = lifn_pkg::NEURONS_DEFAULT,
  parameter int FIFO_DEPTH = lifn_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  lifn_pkg::item_t        item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output lifn_pkg::result_t      result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  lifn_pkg::cfg_index_t   cfg_index,
  input  logic [lifn_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lifn_pkg::*;

  localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int PW = $clog2(FIFO_DEPTH) + 1;

  logic [16:0] leak_factor, step_time;
  logic [30:0] step_rate, refractory_period;

  logic clr_busy;
  logic [AW-1:0] clr_addr;
  logic [PW-1:0] pending;
  logic accept, pop, hazard;

  logic [31:0] v_rd, r_rd;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0] v_wr, r_wr;

  ctl_t s1, s2, s3, s4, s5;
  logic signed [31:0] j1;
  logic signed [32:0] diff2;
  logic [30:0] v2, v3, v4;
  logic [30:0] rs2, rs3, rs4, rs5;
  logic signed [50:0] pdv3;
  logic [61:0] pr3;
  logic signed [34:0] dv4, dv5;
  logic [16:0] mult4;
  logic [47:0] vm5;

  div_tag_t d_tag, d_out;
  logic [33:0] d_rem, d_div;
  logic [15:0] d_q;
  ctl_t d_ctl [DIV_STAGES];

  div_tag_t m_tag;
  logic [33:0] m_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      leak_factor <= LEAK_FACTOR_RESET;
      step_time <= STEP_TIME_RESET;
      step_rate <= STEP_RATE_RESET;
      refractory_period <= REFRACTORY_PERIOD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LEAK_FACTOR:       leak_factor <= cfg_data[16:0];
        CFG_STEP_TIME:         step_time <= cfg_data[16:0];
        CFG_STEP_RATE:         step_rate <= cfg_data[30:0];
        CFG_REFRACTORY_PERIOD: refractory_period <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < DIV_STAGES; i++) begin
      hazard |= d_ctl[i].valid && d_ctl[i].live && d_ctl[i].idx == item.neuron_index;
    end
    hazard |= s1.valid && s1.live && s1.idx == item.neuron_index;
    hazard |= s2.valid && s2.live && s2.idx == item.neuron_index;
    hazard |= s3.valid && s3.live && s3.idx == item.neuron_index;
    hazard |= s4.valid && s4.live && s4.idx == item.neuron_index;
    hazard |= s5.valid && s5.live && s5.idx == item.neuron_index;
    hazard |= m_tag.ctl.valid && m_tag.ctl.live && m_tag.ctl.idx == item.neuron_index;
  end

  assign item_ready = !clr_busy && (pending < PW'(FIFO_DEPTH)) && !hazard;
  assign accept = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
      pending <= '0;
    end else begin
      if (clr_busy) begin
        clr_addr <= AW'(clr_addr + 1'b1);
        if (clr_addr == AW'(NEURONS - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      pending <= PW'(pending + accept - pop);
    end
  end

  lifn_ram #(.WIDTH(32), .DEPTH(NEURONS)) u_v_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(v_wr),
    .rd_en(accept), .rd_addr(AW'(item.neuron_index)), .rd_data(v_rd)
  );

  lifn_ram #(.WIDTH(32), .DEPTH(NEURONS)) u_r_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(r_wr),
    .rd_en(accept), .rd_addr(AW'(item.neuron_index)), .rd_data(r_rd)
  );

  // Stage 1: state words arrive from the RAMs.
  always_ff @(posedge clk) begin
    j1 <= item.input_current;
    s1 <= '{valid: accept,
            live: 17'(item.neuron_index) < 17'(NEURONS),
            idx: item.neuron_index};
    if (rst) begin
      s1.valid <= 1'b0;
    end
  end

  // Stage 2: difference to the input current and refractory countdown.
  always_ff @(posedge clk) begin
    s2 <= s1;
    diff2 <= $signed({j1[31], j1}) - $signed({1'b0, v_rd});
    v2 <= v_rd[30:0];
    rs2 <= (r_rd > {15'd0, step_time}) ? 31'(r_rd - {15'd0, step_time}) : '0;
    if (rst) begin
      s2.valid <= 1'b0;
    end
  end

  // Stage 3: leak and refractory products.
  always_ff @(posedge clk) begin
    s3 <= s2;
    pdv3 <= $signed({1'b0, leak_factor}) * diff2;
    pr3 <= rs2 * step_rate;
    v3 <= v2;
    rs3 <= rs2;
    if (rst) begin
      s3.valid <= 1'b0;
    end
  end

  logic signed [34:0] dv3;
  logic signed [35:0] vsum3;
  logic [45:0] hi3;

  assign dv3 = 35'(pdv3 >>> 16);
  assign vsum3 = $signed({5'd0, v3}) + 36'(dv3);
  assign hi3 = pr3[61:16];

  // Stage 4: integrated voltage and refractory scale.
  always_ff @(posedge clk) begin
    s4 <= s3;
    dv4 <= dv3;
    rs4 <= rs3;
    if (vsum3 < 0) begin
      v4 <= '0;
    end else if (vsum3 > $signed({4'd0, MAX_Q16})) begin
      v4 <= MAX_Q16[30:0];
    end else begin
      v4 <= vsum3[30:0];
    end
    mult4 <= (hi3 >= 46'(ONE_Q16)) ? '0 : 17'(ONE_Q16 - hi3[16:0]);
    if (rst) begin
      s4.valid <= 1'b0;
    end
  end

  // Stage 5: scaled voltage.
  always_ff @(posedge clk) begin
    s5 <= s4;
    dv5 <= dv4;
    rs5 <= rs4;
    vm5 <= v4 * mult4;
    if (rst) begin
      s5.valid <= 1'b0;
    end
  end

  logic [31:0] v5;
  logic spike5;
  logic [30:0] over5;

  assign v5 = vm5[47:16];
  assign spike5 = v5 > {15'd0, ONE_Q16};
  assign over5 = 31'(v5 - {15'd0, ONE_Q16});

  always_comb begin
    d_tag.ctl = s5;
    d_tag.refr = rs5;
    d_tag.v_new = spike5 ? '0 : v5[16:0];
    d_tag.spike = spike5;
    d_tag.dv_pos = !dv5[34] && (dv5 != '0);
    d_tag.sat = {3'd0, over5} >= dv5[33:0];
    d_rem = {3'd0, over5};
    d_div = dv5[33:0];
  end

  lifn_divider u_div (
    .clk(clk), .rst(rst), .tag(d_tag), .rem(d_rem), .divisor(d_div),
    .tag_out(d_out), .quotient(d_q), .stage_ctl(d_ctl)
  );

  logic [16:0] over_d, frac_d;

  always_comb begin
    if (!d_out.dv_pos) begin
      over_d = '0;
    end else if (d_out.sat) begin
      over_d = ONE_Q16;
    end else begin
      over_d = {1'b0, d_q};
    end
    frac_d = 17'(ONE_Q16 - over_d);
  end

  // Final stage: refractory restart product, then write-back.
  always_ff @(posedge clk) begin
    m_tag <= d_out;
    m_prod <= step_time * frac_d;
    if (rst) begin
      m_tag.ctl.valid <= 1'b0;
    end
  end

  logic [31:0] nr_sum;
  logic [30:0] r_new;

  assign nr_sum = {1'b0, refractory_period} + {14'd0, m_prod[33:16]};
  assign r_new = !m_tag.spike ? m_tag.refr
               : (nr_sum > MAX_Q16) ? MAX_Q16[30:0] : nr_sum[30:0];

  always_comb begin
    if (clr_busy) begin
      wr_en = 1'b1;
      wr_addr = clr_addr;
      v_wr = '0;
      r_wr = '0;
    end else begin
      wr_en = m_tag.ctl.valid && m_tag.ctl.live;
      wr_addr = AW'(m_tag.ctl.idx);
      v_wr = {15'd0, m_tag.v_new};
      r_wr = {1'b0, r_new};
    end
  end

  result_t res_m;

  assign res_m = '{spike_neuron: m_tag.ctl.idx, spike: m_tag.ctl.live && m_tag.spike};
  assign pop = result_valid && result_ready;

  lifn_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk(clk), .rst(rst), .push(m_tag.ctl.valid), .push_data(res_m),
    .pop(pop), .not_empty(result_valid), .head(result)
  );

endmodule

FILE: rtl/lifn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIF port checker
// Checks the behaviour seen on the ports of the neuron update block.
// ----------------------------------------------------------------------------
module lifn_checker #(
  parameter int NEURONS = lifn_pkg::NEURONS_DEFAULT
) (
  input logic              clk,
  input logic              rst,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input lifn_pkg::result_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("Result word changed before it was taken.");

  a_spike_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.spike |-> 17'(result.spike_neuron) < 17'(NEURONS))
    else $error("Spike reported for a neuron outside the array.");

  a_clear_ready: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !item_ready)
    else $error("Item taken during the clearing pass.");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !result_valid)
    else $error("Result shown straight after reset.");

endmodule

bind lif_neuron_update lifn_checker #(.NEURONS(NEURONS)) u_lifn_checker (
  .clk(clk), .rst(rst), .item_ready(item_ready), .result_valid(result_valid),
  .result_ready(result_ready), .result(result)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIF neuron update testbench
// Drives neuron current words with random gaps and result stalls, predicts
// each spike flag from a local copy of voltage, refractory time and the
// registers, and checks every result word in order.
// ----------------------------------------------------------------------------
module tb;
  import lifn_pkg::*;

  localparam int NEURON_COUNT = 1024;
  localparam longint CYCLE_LIMIT = 600000;

  class spike_scoreboard;
    longint unsigned leak, dt, rate, tref;
    longint volt [NEURON_COUNT];
    longint refr [NEURON_COUNT];
    result_t pending [$];
    int errors;

    function new();
      leak = LEAK_FACTOR_RESET;
      dt = STEP_TIME_RESET;
      rate = STEP_RATE_RESET;
      tref = REFRACTORY_PERIOD_RESET;
      foreach (volt[i]) begin
        volt[i] = 0;
        refr[i] = 0;
      end
      errors = 0;
    endfunction

    function longint fl16(longint p);
      if (p >= 0) return p >>> 16;
      return -((-p + 65535) >>> 16);
    endfunction

    function longint clip(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
    endfunction

    function void set_register(cfg_index_t idx, logic [31:0] data);
      case (idx)
        CFG_LEAK_FACTOR: leak = data[16:0];
        CFG_STEP_TIME: dt = data[16:0];
        CFG_STEP_RATE: rate = data[30:0];
        CFG_REFRACTORY_PERIOD: tref = data[30:0];
        default: ;
      endcase
    endfunction

    function void note_item(item_t it);
      longint v, r, dv, mult, over;
      longint unsigned prod;
      result_t res;
      int n;
      n = it.neuron_index;
      res.spike_neuron = it.neuron_index;
      res.spike = 1'b0;
      v = volt[n];
      r = refr[n];
      dv = fl16(longint'(leak) * (longint'(it.input_current) - v));
      v = clip(v + dv, 0, 64'h7fffffff);
      r = r - longint'(dt);
      if (r < 0) r = 0;
      prod = longint'(r) * rate;
      mult = clip(65536 - longint'(prod >> 16), 0, 65536);
      v = (v * mult) >>> 16;
      if (v > 65536) begin
        res.spike = 1'b1;
        over = 0;
        if (dv > 0) over = ((v - 65536) << 16) / dv;
        over = clip(over, 0, 65536);
        r = clip(longint'(tref) + ((longint'(dt) * (65536 - over)) >>> 16), 0,
                 64'h7fffffff);
        v = 0;
      end
      volt[n] = v;
      refr[n] = r;
      pending.push_back(res);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word expected none actual %0d/%0b", $time,
                 got.spike_neuron, got.spike);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.spike_neuron !== want.spike_neuron) begin
        $display("%0t: spike_neuron expected %0d actual %0d", $time,
                 want.spike_neuron, got.spike_neuron);
        errors++;
      end
      if (got.spike !== want.spike) begin
        $display("%0t: spike for neuron %0d expected %0b actual %0b", $time,
                 want.spike_neuron, want.spike, got.spike);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic item_valid, item_ready, result_valid, result_ready, cfg_valid, cfg_ready;
  item_t item;
  result_t result;
  cfg_index_t cfg_index;
  logic [31:0] cfg_data;
  spike_scoreboard sb;
  longint cycles = 0;
  bit steady;

  lif_neuron_update DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    sb = new();
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("lif_neuron_update: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
    if (rst) result_ready <= 1'b0;
    else result_ready <= steady || ($urandom_range(99) >= 25);
  end

  task automatic send_item(logic [9:0] n, logic [31:0] cur);
    if (!steady && $urandom_range(99) < 25) begin
      item_valid <= 1'b0;
      do @(posedge clk); while (!steady && $urandom_range(99) < 25);
    end
    item_valid <= 1'b1;
    item <= '{neuron_index: n, input_current: cur};
    do @(posedge clk); while (!item_ready);
    sb.note_item('{neuron_index: n, input_current: cur});
  endtask

  task automatic write_register(cfg_index_t idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_phase(int count, int hot);
    logic [31:0] cur;
    for (int i = 0; i < count; i++) begin
      steady = (i >= count / 3 && i < count / 2);
      case ($urandom_range(9))
        0: cur = $urandom();
        1: cur = -$urandom_range(200000);
        2: cur = 32'h7fffffff;
        default: cur = $urandom_range(400000);
      endcase
      send_item(10'(($urandom_range(3) != 0) ? $urandom_range(hot - 1)
                                             : $urandom_range(1023)),
                cur);
    end
    steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_LEAK_FACTOR;
    cfg_data = '0;
    result_ready = 1'b0;
    steady = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_item(10'd0, 32'h7fffffff);
    send_item(10'd1023, 32'h80000000);
    send_item(10'd0, 32'h7fffffff);
    send_item(10'd0, 32'h00010000);
    send_item(10'd5, 32'hffffffff);
    send_item(10'd1023, 32'h7fffffff);
    for (int i = 0; i < 6; i++) send_item(10'd7, 32'h00040000);
    drain();

    write_register(CFG_LEAK_FACTOR, 32'd65536);
    write_register(CFG_STEP_TIME, 32'd1);
    write_register(CFG_STEP_RATE, 32'h7fffffff);
    write_register(CFG_REFRACTORY_PERIOD, 32'd0);
    write_register(3'd6, 32'hffffffff);
    for (int i = 0; i < 6; i++) send_item(10'd9, 32'h00030000);
    send_item(10'd9, 32'h80000000);
    drain();

    write_register(CFG_LEAK_FACTOR, 32'd0);
    write_register(CFG_STEP_TIME, 32'd65536);
    write_register(CFG_STEP_RATE, 32'd65536);
    write_register(CFG_REFRACTORY_PERIOD, 32'h7fffffff);
    send_item(10'd9, 32'h7fffffff);
    send_item(10'd100, 32'h7fffffff);
    random_phase(100, 16);
    drain();

    write_register(CFG_LEAK_FACTOR, 32'hffffffff);
    write_register(CFG_STEP_TIME, 32'hffffffff);
    write_register(CFG_STEP_RATE, 32'hffffffff);
    write_register(CFG_REFRACTORY_PERIOD, 32'hffffffff);
    random_phase(100, 16);
    drain();

    write_register(CFG_LEAK_FACTOR, 32'(LEAK_FACTOR_RESET));
    write_register(CFG_STEP_TIME, 32'(STEP_TIME_RESET));
    write_register(CFG_STEP_RATE, 32'(STEP_RATE_RESET));
    write_register(CFG_REFRACTORY_PERIOD, 32'(REFRACTORY_PERIOD_RESET));
    random_phase(450, 8);
    drain();

    write_register(CFG_LEAK_FACTOR, $urandom_range(65536));
    write_register(CFG_STEP_TIME, $urandom_range(65536, 1));
    write_register(CFG_STEP_RATE, $urandom_range(32'h7fffffff, 65536));
    write_register(CFG_REFRACTORY_PERIOD, $urandom_range(4000));
    random_phase(600, 32);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("lif_neuron_update: match");
    end else begin
      $display("lif_neuron_update: mismatch");
    end
    $finish;
  end
endmodule

FILE: lif_neuron_update.f
rtl/lifn_pkg.sv
rtl/lifn_ram.sv
rtl/lifn_divider.sv
rtl/lifn_fifo.sv
rtl/lif_neuron_update.sv
rtl/lifn_checker.sv
tb/tb.sv
